// ----- rtl/core/hnd_pkg.sv -----
// ----------------------------------------------------------------------------
// hnd_pkg: shared types and constants of the nearest descriptor matcher
// Field widths, request codes, distance constants and the 64-bit bit count.
// ----------------------------------------------------------------------------
package hnd_pkg;

   // payload field widths
   localparam int REQ_W   = 2;
   localparam int KEY_W   = 16;
   localparam int WORD_W  = 64;
   localparam int DIST_W  = 9;
   localparam int LIMIT_W = 8;

   // full descriptor as carried on the request channel
   localparam int DESC_MAX   = 256;
   localparam int NUM_CHUNKS = DESC_MAX / WORD_W;
   localparam int CHUNK_CNT_W = 7;

   // request codes
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

   // running best starts at 256, the largest real distance
   localparam logic [DIST_W-1:0] START_DIST = 9'd256;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd50;

   // scored entry handed from the distance unit to the control
   typedef struct packed {
      logic              vld;
      logic [KEY_W-1:0]  key;
      logic [DIST_W-1:0] distance;
   } score_type;

   // population count of one 64-bit chunk, pairwise tree in six levels
   function automatic logic [CHUNK_CNT_W-1:0] popcnt64(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] s1;
      logic [WORD_W-1:0] s2;
      logic [WORD_W-1:0] s3;
      logic [WORD_W-1:0] s4;
      logic [WORD_W-1:0] s5;
      logic [WORD_W-1:0] s6;
      s1 = (v & 64'h5555_5555_5555_5555) + ((v >> 1) & 64'h5555_5555_5555_5555);
      s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
      s3 = (s2 & 64'h0F0F_0F0F_0F0F_0F0F) + ((s2 >> 4) & 64'h0F0F_0F0F_0F0F_0F0F);
      s4 = (s3 & 64'h00FF_00FF_00FF_00FF) + ((s3 >> 8) & 64'h00FF_00FF_00FF_00FF);
      s5 = (s4 & 64'h0000_FFFF_0000_FFFF) + ((s4 >> 16) & 64'h0000_FFFF_0000_FFFF);
      s6 = (s5 & 64'h0000_0000_FFFF_FFFF) + ((s5 >> 32) & 64'h0000_0000_FFFF_FFFF);
      return s6[CHUNK_CNT_W-1:0];
   endfunction

endpackage

// ----- rtl/core/hnd_ifs.sv -----
// ----------------------------------------------------------------------------
// hnd_ifs: channel interfaces of the nearest descriptor matcher
// Request, response and control register write channels, valid/ready each.
// ----------------------------------------------------------------------------

// request channel: clear, load or query
interface hnd_req_if;
   logic                         valid;
   logic                         ready;
   logic [hnd_pkg::REQ_W-1:0]    req_type;
   logic [hnd_pkg::KEY_W-1:0]    key_index;
   logic [hnd_pkg::WORD_W-1:0]   desc_word0;
   logic [hnd_pkg::WORD_W-1:0]   desc_word1;
   logic [hnd_pkg::WORD_W-1:0]   desc_word2;
   logic [hnd_pkg::WORD_W-1:0]   desc_word3;

   modport source (output valid, req_type, key_index, desc_word0, desc_word1,
                   desc_word2, desc_word3, input ready);
   modport sink   (input valid, req_type, key_index, desc_word0, desc_word1,
                   desc_word2, desc_word3, output ready);
endinterface

// response channel: one match per successful query
interface hnd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hnd_pkg::KEY_W-1:0]    query_index;
   logic [hnd_pkg::KEY_W-1:0]    match_index;
   logic [hnd_pkg::DIST_W-1:0]   match_distance;

   modport source (output valid, query_index, match_index, match_distance,
                   input ready);
   modport sink   (input valid, query_index, match_index, match_distance,
                   output ready);
endinterface

// control register write channel: match distance limit
interface hnd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [hnd_pkg::LIMIT_W-1:0]  wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

// ----- rtl/core/hnd_cell.sv -----
// ----------------------------------------------------------------------------
// hnd_cell: one store cell of the descriptor chain
// Holds one entry (keypoint index and descriptor) and passes it on when shifted.
// ----------------------------------------------------------------------------
module hnd_cell #(
   parameter int ENTRY_W = 272
) (
   input  logic               clock,
   input  logic               shift_en,
   input  logic [ENTRY_W-1:0] entry_in,
   output logic [ENTRY_W-1:0] entry_out
);

   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] entry_in_mux;

   // take the neighbor's entry on a shift, hold otherwise
   assign entry_in_mux = shift_en ? entry_in : entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in_mux;
   end

   assign entry_out = entry_ff;

endmodule

// ----- rtl/core/hnd_dist.sv -----
// ----------------------------------------------------------------------------
// hnd_dist: Hamming distance unit
// Counts differing bits per 64-bit chunk into registers, then sums the chunks.
// ----------------------------------------------------------------------------
module hnd_dist #(
   parameter int DESC_BITS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  logic [hnd_pkg::KEY_W-1:0]   in_key,
   input  logic [DESC_BITS-1:0]        desc_a,
   input  logic [DESC_BITS-1:0]        desc_b,
   output hnd_pkg::score_type          score
);

   logic [hnd_pkg::DESC_MAX-1:0]    diff_full;
   logic [hnd_pkg::CHUNK_CNT_W-1:0] cnt_in [hnd_pkg::NUM_CHUNKS];
   logic [hnd_pkg::CHUNK_CNT_W-1:0] cnt_ff [hnd_pkg::NUM_CHUNKS];
   logic                            vld_ff;
   logic [hnd_pkg::KEY_W-1:0]       key_ff;
   logic [hnd_pkg::DIST_W-1:0]      sum;

   // differing bits, zero above the descriptor length
   assign diff_full = hnd_pkg::DESC_MAX'(desc_a ^ desc_b);

   // per-chunk bit counts
   always_comb begin
      for (int c = 0; c < hnd_pkg::NUM_CHUNKS; c++) begin
         cnt_in[c] = hnd_pkg::popcnt64(diff_full[c*hnd_pkg::WORD_W +: hnd_pkg::WORD_W]);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < hnd_pkg::NUM_CHUNKS; c++) begin
         cnt_ff[c] <= cnt_in[c];
      end
      key_ff <= in_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   // chunk totals into the full distance
   always_comb begin
      sum = '0;
      for (int c = 0; c < hnd_pkg::NUM_CHUNKS; c++) begin
         sum = sum + hnd_pkg::DIST_W'(cnt_ff[c]);
      end
   end

   assign score.vld      = vld_ff;
   assign score.key      = key_ff;
   assign score.distance = sum;

endmodule

// ----- rtl/core/hamming_nearest_descriptor_match_top.sv -----
// ----------------------------------------------------------------------------
// hamming_nearest_descriptor_match_top: nearest binary descriptor matcher
// Store of descriptors in a chain of cells, rotated past one distance unit.
// ----------------------------------------------------------------------------
//
//   channel  direction  carries
//   req_*    in         req_type, key_index, desc_word0..3
//   rsp_*    out        query_index, match_index, match_distance
//   csr_*    in         wdata: match distance limit (reset 50)
//
// After its transfer, a query rotates the cell chain once around, one entry past
// the distance unit per cycle, then drains the distance stage and decides in
// its final step. Reset is synchronous; it clears the entry count and the
// control and returns the limit to its reset value of 50.
// A stalled response holds only the final step of a query; clears and loads
// are taken while a response waits.
// ----------------------------------------------------------------------------
module hamming_nearest_descriptor_match_top #(
   parameter int MAX_ENTRIES = 256,
   parameter int DESC_BITS   = 256
) (
   input  logic      clock,
   input  logic      reset,
   hnd_req_if.sink   req_port,
   hnd_rsp_if.source rsp_port,
   hnd_csr_if.sink   csr_port
);

   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int ENTRY_W = hnd_pkg::KEY_W + DESC_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_STEP  = IDX_W'(MAX_ENTRIES - 1);
   localparam logic [CNT_W:0]   WRAP_SUM   = (CNT_W+1)'(MAX_ENTRIES);

   // control states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [IDX_W-1:0]               step_ff, step_in;
   logic [hnd_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [DESC_BITS-1:0]           qdesc_ff, qdesc_in;
   logic [hnd_pkg::KEY_W-1:0]      qkey_ff, qkey_in;
   logic [hnd_pkg::DIST_W-1:0]     best_ff, best_in;
   logic [hnd_pkg::KEY_W-1:0]      best_key_ff, best_key_in;
   logic                           found_ff, found_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [hnd_pkg::KEY_W-1:0]      rsp_qkey_ff, rsp_qkey_in;
   logic [hnd_pkg::KEY_W-1:0]      rsp_mkey_ff, rsp_mkey_in;
   logic [hnd_pkg::DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;

   logic                           req_xfer;
   logic                           load_ok;
   logic                           scanning;
   logic                           shift_en;
   logic [hnd_pkg::DESC_MAX-1:0]   req_desc_full;
   logic [DESC_BITS-1:0]           req_desc;
   logic [ENTRY_W-1:0]             cell_q [MAX_ENTRIES];
   logic [ENTRY_W-1:0]             tap;
   logic [CNT_W:0]                 pos_sum;
   logic                           tap_vld;
   logic                           is_match;
   hnd_pkg::score_type             score;

   // handshakes
   assign req_port.ready = (state_ff == ST_IDLE);
   assign csr_port.ready = 1'b1;
   assign req_xfer       = req_port.valid && req_port.ready;

   assign req_desc_full = {req_port.desc_word3, req_port.desc_word2,
                           req_port.desc_word1, req_port.desc_word0};
   assign req_desc      = req_desc_full[DESC_BITS-1:0];

   // a load shifts a new entry in at the head unless the store is full
   assign load_ok  = req_xfer && (req_port.req_type == hnd_pkg::REQ_LOAD)
                     && (cnt_ff < FULL_COUNT);
   assign scanning = (state_ff == ST_SCAN);
   assign shift_en = scanning || load_ok;

   // chain of cells, closed into a ring while scanning
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [ENTRY_W-1:0] entry_src;
      if (i == 0) begin : g_head
         assign entry_src = scanning ? cell_q[MAX_ENTRIES-1]
                                     : {req_port.key_index, req_desc};
      end else begin : g_body
         assign entry_src = cell_q[i-1];
      end
      hnd_cell #(.ENTRY_W(ENTRY_W)) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .entry_in  (entry_src),
         .entry_out (cell_q[i])
      );
   end

   // the tail cell shows the oldest valid entry after the invalid ones
   assign tap     = cell_q[MAX_ENTRIES-1];
   assign pos_sum = (CNT_W+1)'(step_ff) + (CNT_W+1)'(cnt_ff);
   assign tap_vld = scanning && (pos_sum >= WRAP_SUM);

   hnd_dist #(.DESC_BITS(DESC_BITS)) u_dist (
      .clock  (clock),
      .reset  (reset),
      .in_vld (tap_vld),
      .in_key (tap[ENTRY_W-1:DESC_BITS]),
      .desc_a (tap[DESC_BITS-1:0]),
      .desc_b (qdesc_ff),
      .score  (score)
   );

   assign is_match = found_ff && (best_ff <= hnd_pkg::DIST_W'(limit_ff));

   // limit register
   always_comb begin
      limit_in = limit_ff;
      if (csr_port.valid && csr_port.ready) begin
         limit_in = csr_port.wdata;
      end
   end

   // control, store count and running best
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      step_in     = step_ff;
      qdesc_in    = qdesc_ff;
      qkey_in     = qkey_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      found_in    = found_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_qkey_in = rsp_qkey_ff;
      rsp_mkey_in = rsp_mkey_ff;
      rsp_dist_in = rsp_dist_ff;

      // response register drains on a transfer
      if (rsp_vld_ff && rsp_port.ready) begin
         rsp_vld_in = 1'b0;
      end

      // strict less-than keeps the earliest entry on ties
      if (score.vld && (score.distance < best_ff)) begin
         best_in     = score.distance;
         best_key_in = score.key;
         found_in    = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_port.req_type)
                  hnd_pkg::REQ_CLEAR: begin
                     cnt_in = '0;
                  end
                  hnd_pkg::REQ_LOAD: begin
                     if (load_ok) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  hnd_pkg::REQ_QUERY: begin
                     state_in = ST_SCAN;
                     step_in  = '0;
                     qdesc_in = req_desc;
                     qkey_in  = req_port.key_index;
                     best_in  = hnd_pkg::START_DIST;
                     found_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            step_in = step_ff + IDX_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!is_match) begin
               state_in = ST_IDLE;
            end else if (!rsp_vld_ff || rsp_port.ready) begin
               state_in    = ST_IDLE;
               rsp_vld_in  = 1'b1;
               rsp_qkey_in = qkey_ff;
               rsp_mkey_in = best_key_ff;
               rsp_dist_in = best_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         limit_ff   <= hnd_pkg::LIMIT_RESET;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         limit_ff   <= limit_in;
         found_ff   <= found_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      qdesc_ff    <= qdesc_in;
      qkey_ff     <= qkey_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      rsp_qkey_ff <= rsp_qkey_in;
      rsp_mkey_ff <= rsp_mkey_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   // response outputs
   assign rsp_port.valid          = rsp_vld_ff;
   assign rsp_port.query_index    = rsp_qkey_ff;
   assign rsp_port.match_index    = rsp_mkey_ff;
   assign rsp_port.match_distance = rsp_dist_ff;

   // store count never passes the capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   // the store is not touched while a query rotates it
   a_cnt_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> $stable(cnt_ff))
      else $error("entry count changed during a scan");

   // scored entries arrive only while the ring turns or drains
   a_score_win: assert property (@(posedge clock) disable iff (reset)
      score.vld |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance result outside a scan");

   // a found entry always beats the start distance
   a_found_best: assert property (@(posedge clock) disable iff (reset)
      (found_ff && state_ff == ST_FINISH) |-> (best_ff < hnd_pkg::START_DIST))
      else $error("best distance not below start value");

   // a new response only follows a drained or departing one
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_vld_ff && !rsp_port.ready) |=>
      $stable(rsp_port.query_index))
      else $error("pending response overwritten");

endmodule

// ----- tb/hamming_nearest_descriptor_match_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hamming_nearest_descriptor_match_top_tb: self-checking bench of the matcher
// Drives clears, loads and queries over the request channel with random gaps,
// stalls the response channel at random and at length, and rewrites the
// distance limit between phases. A scoreboard keeps its own copy of the store,
// predicts the nearest entry of each query and checks every response in order.
// ----------------------------------------------------------------------------
module hamming_nearest_descriptor_match_top_tb;

   localparam int MAX_ENTRIES = 256;
   localparam int DESC_BITS   = 256;
   localparam int DESC_W      = hnd_pkg::DESC_MAX;
   localparam int HOLD_CYCLES = 3000;

   // request code the block has to ignore
   localparam logic [hnd_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [hnd_pkg::REQ_W-1:0] kind;
      logic [hnd_pkg::KEY_W-1:0] key;
      logic [DESC_W-1:0]         desc;
   } request_type;

   typedef struct packed {
      logic [hnd_pkg::KEY_W-1:0]  query_index;
      logic [hnd_pkg::KEY_W-1:0]  match_index;
      logic [hnd_pkg::DIST_W-1:0] match_distance;
   } match_type;

   // shadow store, nearest entry search and in-order match check
   class match_scoreboard;
      logic [DESC_W-1:0]           desc_store [MAX_ENTRIES];
      logic [hnd_pkg::KEY_W-1:0]   key_store [MAX_ENTRIES];
      logic [DESC_W-1:0]           desc_mask;
      int unsigned                 count;
      logic [hnd_pkg::LIMIT_W-1:0] limit;
      match_type                   pending_matches [$];
      int unsigned                 errors;

      function new();
         for (int b = 0; b < DESC_W; b++) desc_mask[b] = (b < DESC_BITS);
         count  = 0;
         limit  = hnd_pkg::LIMIT_RESET;
         errors = 0;
      endfunction

      function void set_limit(logic [hnd_pkg::LIMIT_W-1:0] value);
         limit = value;
      endfunction

      // update the store on an accepted request, queue a match if one is due
      function void accept_request(request_type r);
         int unsigned               best;
         int unsigned               distance;
         logic [hnd_pkg::KEY_W-1:0] best_key;
         bit                        found;
         match_type                 m;
         case (r.kind)
            hnd_pkg::REQ_CLEAR: count = 0;
            hnd_pkg::REQ_LOAD: begin
               // a load into a full store is dropped
               if (count < MAX_ENTRIES) begin
                  desc_store[count] = r.desc;
                  key_store[count]  = r.key;
                  count++;
               end
            end
            hnd_pkg::REQ_QUERY: begin
               best     = hnd_pkg::START_DIST;
               best_key = '0;
               found    = 1'b0;
               // strict less-than keeps the earliest entry on a tie
               for (int e = 0; e < count; e++) begin
                  distance = $countones((desc_store[e] ^ r.desc) & desc_mask);
                  if (distance < best) begin
                     best     = distance;
                     best_key = key_store[e];
                     found    = 1'b1;
                  end
               end
               if (found && best <= limit) begin
                  m.query_index    = r.key;
                  m.match_index    = best_key;
                  m.match_distance = best[hnd_pkg::DIST_W-1:0];
                  pending_matches  = {pending_matches, m};
               end
            end
            default: ;
         endcase
      endfunction

      // compare one response against the oldest predicted match
      function void check_match(match_type got);
         match_type want;
         if (pending_matches.size() == 0) begin
            $error("unexpected match: query_index %0d match_index %0d match_distance %0d",
                   got.query_index, got.match_index, got.match_distance);
            errors++;
         end else begin
            want = pending_matches.pop_front();
            if (got.query_index !== want.query_index) begin
               $error("query_index expected %0d actual %0d", want.query_index, got.query_index);
               errors++;
            end
            if (got.match_index !== want.match_index) begin
               $error("match_index expected %0d actual %0d", want.match_index, got.match_index);
               errors++;
            end
            if (got.match_distance !== want.match_distance) begin
               $error("match_distance expected %0d actual %0d",
                      want.match_distance, got.match_distance);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   hnd_req_if req_ch ();
   hnd_rsp_if rsp_ch ();
   hnd_csr_if csr_ch ();

   match_scoreboard sb;

   int unsigned requests_sent = 0;
   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   bit          hold_off_req  = 1'b0;

   hamming_nearest_descriptor_match_top #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .DESC_BITS   (DESC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // check every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_match(match_type'({rsp_ch.query_index, rsp_ch.match_index,
                                     rsp_ch.match_distance}));
   end

   function automatic logic [DESC_W-1:0] rand_desc();
      return {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [DESC_W-1:0] flip_bits(logic [DESC_W-1:0] d, int n);
      logic [DESC_W-1:0] v;
      v = d;
      for (int i = 0; i < n; i++) v[$urandom_range(0, DESC_W - 1)] ^= 1'b1;
      return v;
   endfunction

   // one request transfer, with an optional idle burst ahead of it
   task automatic transfer_request(input logic [hnd_pkg::REQ_W-1:0] kind,
                                   input logic [hnd_pkg::KEY_W-1:0] key,
                                   input logic [DESC_W-1:0] d);
      request_type r;
      r.kind = kind;
      r.key  = key;
      r.desc = d;
      if (req_idle_pct != 0 && $urandom_range(1, 100) <= req_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.key_index  <= key;
      req_ch.desc_word0 <= d[63:0];
      req_ch.desc_word1 <= d[127:64];
      req_ch.desc_word2 <= d[191:128];
      req_ch.desc_word3 <= d[255:192];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.accept_request(r);
      if (kind != REQ_UNUSED) requests_sent++;
   endtask

   // query close to a stored entry, or anywhere when the store is empty
   task automatic query_near(input int reach);
      logic [DESC_W-1:0] d;
      if (sb.count == 0)
         d = rand_desc();
      else
         d = flip_bits(sb.desc_store[$urandom_range(0, sb.count - 1)],
                       $urandom_range(0, reach));
      transfer_request(hnd_pkg::REQ_QUERY, 16'($urandom), d);
   endtask

   task automatic drain_matches();
      while (sb.pending_matches.size() != 0) @(posedge clock);
   endtask

   // stop sending, wait for the last match and for a query that gives none
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      drain_matches();
      repeat (MAX_ENTRIES + 8) @(posedge clock);
   endtask

   task automatic write_match_limit(input logic [hnd_pkg::LIMIT_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.wdata <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      sb.set_limit(value);
   endtask

   // one frame: a clear in most frames, fresh loads with some duplicates, then mixed requests
   task automatic run_frame();
      int                n_loads;
      int                n_queries;
      int                reach;
      logic [DESC_W-1:0] d;
      n_loads   = $urandom_range(1, 12);
      n_queries = $urandom_range(2, 10);
      if ($urandom_range(0, 4) != 0)
         transfer_request(hnd_pkg::REQ_CLEAR, 16'($urandom), rand_desc());
      for (int i = 0; i < n_loads; i++) begin
         if (sb.count != 0 && $urandom_range(0, 7) == 0)
            d = sb.desc_store[$urandom_range(0, sb.count - 1)];
         else
            d = rand_desc();
         transfer_request(hnd_pkg::REQ_LOAD, 16'($urandom), d);
      end
      reach = (sb.limit > 60) ? 70 : sb.limit + 6;
      for (int i = 0; i < n_queries; i++) begin
         case ($urandom_range(0, 9))
            0: transfer_request(REQ_UNUSED, 16'($urandom), rand_desc());
            1: transfer_request(hnd_pkg::REQ_QUERY, 16'($urandom), rand_desc());
            2: transfer_request(hnd_pkg::REQ_LOAD, 16'($urandom), rand_desc());
            default: query_near(reach);
         endcase
      end
   endtask

   // main sequence
   initial begin
      logic [DESC_W-1:0]           zeros;
      logic [DESC_W-1:0]           ones;
      logic [DESC_W-1:0]           a_desc;
      logic [DESC_W-1:0]           dropped;
      logic [hnd_pkg::LIMIT_W-1:0] new_limit;
      sb      = new();
      zeros   = '0;
      ones    = '1;
      dropped = '0;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = hnd_pkg::REQ_CLEAR;
      req_ch.key_index  = '0;
      req_ch.desc_word0 = '0;
      req_ch.desc_word1 = '0;
      req_ch.desc_word2 = '0;
      req_ch.desc_word3 = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.wdata      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset limit
      req_idle_pct  = 20;
      rsp_stall_pct = 20;
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0001, rand_desc());
      transfer_request(REQ_UNUSED, 16'hFFFF, ones);
      transfer_request(hnd_pkg::REQ_LOAD, 16'h0000, zeros);
      transfer_request(hnd_pkg::REQ_LOAD, 16'hFFFF, ones);
      transfer_request(hnd_pkg::REQ_QUERY, 16'hFFFF, zeros);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0000, ones);
      // duplicate entry: the earlier one must win the tie
      transfer_request(hnd_pkg::REQ_LOAD, 16'h1234, zeros);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h4321, zeros);
      // distance right at the limit and one above it
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0032, {{206{1'b0}}, {50{1'b1}}});
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0033, {{205{1'b0}}, {51{1'b1}}});
      // query after a clear finds an empty store
      transfer_request(hnd_pkg::REQ_CLEAR, 16'hA5A5, ones);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0002, zeros);
      // complement of the only entry lies at distance 256
      a_desc = rand_desc();
      transfer_request(hnd_pkg::REQ_LOAD, 16'h5A5A, a_desc);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0003, ~a_desc);

      quiesce();
      write_match_limit(8'd255);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0004, ~a_desc);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0005,
                       ~a_desc ^ (256'd1 << $urandom_range(0, DESC_W - 1)));
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0006, a_desc);

      quiesce();
      write_match_limit(8'd0);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0007, a_desc);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0008, flip_bits(a_desc, 1));
      transfer_request(REQ_UNUSED, 16'h0000, zeros);
      transfer_request(hnd_pkg::REQ_QUERY, 16'h0009, a_desc);

      // random phases, each at its own limit and idling mix
      for (int phase = 0; phase < 6; phase++) begin
         quiesce();
         case (phase)
            0: begin
               new_limit     = hnd_pkg::LIMIT_RESET;
               req_idle_pct  = 25;
               rsp_stall_pct = 25;
            end
            1: begin
               new_limit     = 8'($urandom_range(20, 90));
               req_idle_pct  = 10;
               rsp_stall_pct = 40;
            end
            2: begin
               new_limit     = 8'd40;
               req_idle_pct  = 5;
               rsp_stall_pct = 5;
            end
            3: begin
               new_limit     = 8'd255;
               req_idle_pct  = 20;
               rsp_stall_pct = 10;
            end
            4: begin
               new_limit     = 8'($urandom_range(0, 12));
               req_idle_pct  = 0;
               rsp_stall_pct = 30;
            end
            default: begin
               new_limit     = 8'($urandom_range(30, 70));
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         write_match_limit(new_limit);

         // fill the store to the top, the last loads are dropped
         if (phase == 2) begin
            transfer_request(hnd_pkg::REQ_CLEAR, 16'($urandom), rand_desc());
            for (int i = 0; i < MAX_ENTRIES + 4; i++) begin
               dropped = rand_desc();
               transfer_request(hnd_pkg::REQ_LOAD, 16'($urandom), dropped);
            end
            transfer_request(hnd_pkg::REQ_QUERY, 16'($urandom), dropped);
            transfer_request(hnd_pkg::REQ_QUERY, 16'($urandom), sb.desc_store[0]);
            transfer_request(hnd_pkg::REQ_QUERY, 16'($urandom),
                             sb.desc_store[MAX_ENTRIES - 1]);
            for (int i = 0; i < 10; i++) query_near(45);
         end

         // long response hold-off while queries keep coming, then a full pause
         if (phase == 3) begin
            transfer_request(hnd_pkg::REQ_CLEAR, 16'($urandom), rand_desc());
            for (int i = 0; i < 4; i++)
               transfer_request(hnd_pkg::REQ_LOAD, 16'($urandom), rand_desc());
            hold_off_req = 1'b1;
            for (int i = 0; i < 8; i++) query_near(20);
            req_ch.valid <= 1'b0;
            drain_matches();
         end

         while (requests_sent < 25 + 100 * (phase + 1)) run_frame();
      end

      quiesce();
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- hamming_nearest_descriptor_match_top.f -----
rtl/core/hnd_pkg.sv
rtl/core/hnd_ifs.sv
rtl/core/hnd_cell.sv
rtl/core/hnd_dist.sv
rtl/core/hamming_nearest_descriptor_match_top.sv
tb/hamming_nearest_descriptor_match_top_tb.sv
